### rtl/twpw_pkg.sv
// Package for the path weighted position counter (paths of three links).
// Holds sizes, register indexes, state codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package twpw_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int CNT_W       = 5;
  localparam int WEIGHT_W    = 16;
  localparam int ACC_W       = 32;
  localparam int NUM_W       = WEIGHT_W + 2;
  localparam int QUO_W       = 17;
  localparam int DIV_STEPS   = 16;
  localparam int DSTEP_W     = 5;
  localparam int LANES       = 4;
  localparam int CFG_IDX_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  localparam logic [1:0] SEL_FIRST_COL  = 2'd0;
  localparam logic [1:0] SEL_SECOND_COL = 2'd1;
  localparam logic [1:0] SEL_FAR_ROW    = 2'd2;
  localparam logic [1:0] SEL_MID_ROW    = 2'd3;

  typedef enum logic [3:0] {
    S_LOAD, S_XP, S_XQ, S_XCHK, S_YQ, S_YP, S_YCHK, S_DIV, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_XP, ADDR_XQ, ADDR_YQ, ADDR_YP
  } addr_sel_t;

  typedef struct packed {
    logic      load_wr;
    logic      start_walk;
    addr_sel_t addr_sel;
    logic      cap_wxp;
    logic      cap_wxq;
    logic      cap_wyq;
    logic      next_x;
    logic      reset_y;
    logic      next_y;
    logic      div_start;
    logic      acc_add;
    logic      emit_start;
    logic      emit_load;
  } cmd_t;

  typedef struct packed {
    logic x_ok;
    logic y_ok;
    logic y_eq_x;
    logic y_last;
    logic walk_last;
    logic div_done;
    logic out_free;
    logic emit_last;
  } status_t;

  // Saturate a node count into 2..hi.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    if (v < CNT_W'(2)) r = CNT_W'(2);
    else if (v > hi)   r = hi;
    else               r = v;
    return r;
  endfunction

endpackage

### rtl/twpw_if.sv
// Valid/ready channel interfaces for weight words and result words.
// Depends on twpw_pkg for field widths.
`timescale 1ns / 1ps

interface twpw_in_if;
  logic                           valid;
  logic                           ready;
  logic [twpw_pkg::WEIGHT_W-1:0]  weight;
  logic                           last_weight;
  modport source(output valid, weight, last_weight, input ready);
  modport sink(input valid, weight, last_weight, output ready);
endinterface

interface twpw_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  vector_select;
  logic [3:0]                  node_index;
  logic [twpw_pkg::ACC_W-1:0]  contribution;
  logic                        last_result;
  modport source(output valid, vector_select, node_index, contribution, last_result,
                 input ready);
  modport sink(input valid, vector_select, node_index, contribution, last_result,
               output ready);
endinterface

### rtl/twpw_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module twpw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read at one address.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/twpw_div.sv
// Four-lane restoring divider: floor(num * 65536 / den), one bit per cycle.
// Depends on twpw_pkg.
`timescale 1ns / 1ps

module twpw_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [twpw_pkg::NUM_W-1:0] den,
  input  logic [twpw_pkg::NUM_W-1:0] num [twpw_pkg::LANES],
  output logic                       done,
  output logic [twpw_pkg::QUO_W-1:0] quo  [twpw_pkg::LANES]
);

  logic [twpw_pkg::NUM_W-1:0]   den_r;
  logic [twpw_pkg::NUM_W-1:0]   rem_r [twpw_pkg::LANES];
  logic [twpw_pkg::QUO_W-1:0]   quo_r [twpw_pkg::LANES];
  logic [twpw_pkg::DSTEP_W-1:0] cnt_r;
  logic                         busy_r;
  logic                         done_r;

  // Control: count the remaining quotient bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= twpw_pkg::DSTEP_W'(twpw_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - twpw_pkg::DSTEP_W'(1);
        if (cnt_r == twpw_pkg::DSTEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Lanes: the top quotient bit comes from num >= den, then one bit a cycle.
  always_ff @(posedge clk) begin
    logic [twpw_pkg::NUM_W:0] sh;
    if (start) den_r <= den;
    for (int l = 0; l < twpw_pkg::LANES; l++) begin
      if (start) begin
        if (num[l] >= den) begin
          rem_r[l] <= num[l] - den;
          quo_r[l] <= twpw_pkg::QUO_W'(1);
        end else begin
          rem_r[l] <= num[l];
          quo_r[l] <= '0;
        end
      end else if (busy_r) begin
        sh = {rem_r[l], 1'b0};
        if (sh >= {1'b0, den_r}) begin
          rem_r[l] <= twpw_pkg::NUM_W'(sh - {1'b0, den_r});
          quo_r[l] <= {quo_r[l][twpw_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_r[l] <= sh[twpw_pkg::NUM_W-1:0];
          quo_r[l] <= {quo_r[l][twpw_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/twpw_dp.sv
// Datapath: weight store, walk counters, divider, accumulators, result word.
// Depends on twpw_pkg, twpw_ram and twpw_div.
`timescale 1ns / 1ps

module twpw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twpw_pkg::cmd_t                cmd,
  output twpw_pkg::status_t             status,
  input  logic [twpw_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                          cfg_we,
  input  logic [twpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twpw_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_select,
  output logic [3:0]                    out_index,
  output logic [twpw_pkg::ACC_W-1:0]    out_value,
  output logic                          out_last
);

  logic [twpw_pkg::CNT_W-1:0]  rows_r, cols_r, nr, nc;
  logic [twpw_pkg::ADDR_W-1:0] load_pos_r;
  logic [twpw_pkg::COL_W-1:0]  p_r, q_r;
  logic [twpw_pkg::ROW_W-1:0]  x_r, y_r;
  logic [twpw_pkg::WEIGHT_W-1:0] wxp_r, wxq_r, wyq_r, rdata;
  logic [twpw_pkg::ACC_W-1:0]  acc_fc_r [twpw_pkg::MAX_COLS];
  logic [twpw_pkg::ACC_W-1:0]  acc_sc_r [twpw_pkg::MAX_COLS];
  logic [twpw_pkg::ACC_W-1:0]  acc_fr_r [twpw_pkg::MAX_ROWS];
  logic [twpw_pkg::ACC_W-1:0]  acc_mr_r [twpw_pkg::MAX_ROWS];
  logic [1:0]                  esel_r;
  logic [3:0]                  eidx_r;
  logic                        out_valid_r;
  logic [1:0]                  out_select_r;
  logic [3:0]                  out_index_r;
  logic [twpw_pkg::ACC_W-1:0]  out_value_r;
  logic                        out_last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= twpw_pkg::CNT_W'(twpw_pkg::MAX_ROWS);
      cols_r <= twpw_pkg::CNT_W'(twpw_pkg::MAX_COLS);
    end else if (cfg_we) begin
      if (cfg_index == twpw_pkg::REG_ROWS) rows_r <= cfg_wdata;
      if (cfg_index == twpw_pkg::REG_COLS) cols_r <= cfg_wdata;
    end
  end

  assign nr = twpw_pkg::clamp_count(rows_r, twpw_pkg::CNT_W'(twpw_pkg::MAX_ROWS));
  assign nc = twpw_pkg::clamp_count(cols_r, twpw_pkg::CNT_W'(twpw_pkg::MAX_COLS));

  // Store address: load pointer or row * C + col.
  logic [twpw_pkg::ROW_W-1:0]     a_row;
  logic [twpw_pkg::COL_W-1:0]     a_col;
  logic [twpw_pkg::ADDR_W:0]      prod;
  logic [twpw_pkg::ADDR_W-1:0]    addr;
  logic [twpw_pkg::ADDR_W+1:0]    walk_addr;
  logic                           store_we;

  always_comb begin
    unique case (cmd.addr_sel)
      twpw_pkg::ADDR_XP: begin a_row = x_r; a_col = p_r; end
      twpw_pkg::ADDR_XQ: begin a_row = x_r; a_col = q_r; end
      twpw_pkg::ADDR_YQ: begin a_row = y_r; a_col = q_r; end
      default:           begin a_row = y_r; a_col = p_r; end
    endcase
    prod      = (twpw_pkg::ADDR_W+1)'(nr * nc);
    walk_addr = (twpw_pkg::ADDR_W+2)'(a_row * nc) + (twpw_pkg::ADDR_W+2)'(a_col);
    store_we  = cmd.load_wr && ({1'b0, load_pos_r} < prod);
    addr      = cmd.load_wr ? load_pos_r : walk_addr[twpw_pkg::ADDR_W-1:0];
  end

  twpw_ram #(
    .WIDTH(twpw_pkg::WEIGHT_W),
    .DEPTH(twpw_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .addr (addr),
    .wdata(in_weight),
    .rdata(rdata)
  );

  // Walk counters over column pairs and row pairs.
  logic [twpw_pkg::CNT_W-1:0] q_inc, q_skip, p_inc;
  logic                       pair_last;

  always_comb begin
    q_inc  = twpw_pkg::CNT_W'(q_r) + twpw_pkg::CNT_W'(1);
    q_skip = (q_inc == twpw_pkg::CNT_W'(p_r)) ? q_inc + twpw_pkg::CNT_W'(1) : q_inc;
    p_inc  = twpw_pkg::CNT_W'(p_r) + twpw_pkg::CNT_W'(1);
    pair_last = (p_inc == nc) && (q_skip >= nc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_pos_r <= '0;
    end else if (cmd.start_walk) begin
      load_pos_r <= '0;
    end else if (store_we) begin
      load_pos_r <= load_pos_r + twpw_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      p_r <= '0;
      q_r <= twpw_pkg::COL_W'(1);
      x_r <= '0;
    end else if (cmd.next_x) begin
      if (twpw_pkg::CNT_W'(x_r) + twpw_pkg::CNT_W'(1) == nr) begin
        x_r <= '0;
        if (q_skip >= nc) begin
          p_r <= p_inc[twpw_pkg::COL_W-1:0];
          q_r <= '0;
        end else begin
          q_r <= q_skip[twpw_pkg::COL_W-1:0];
        end
      end else begin
        x_r <= x_r + twpw_pkg::ROW_W'(1);
      end
    end
    if (cmd.reset_y)     y_r <= '0;
    else if (cmd.next_y) y_r <= y_r + twpw_pkg::ROW_W'(1);
    if (cmd.cap_wxp) wxp_r <= rdata;
    if (cmd.cap_wxq) wxq_r <= rdata;
    if (cmd.cap_wyq) wyq_r <= rdata;
  end

  // Divider operands: four numerators over one denominator.
  logic [twpw_pkg::NUM_W-1:0] den;
  logic [twpw_pkg::NUM_W-1:0] num [twpw_pkg::LANES];
  logic [twpw_pkg::QUO_W-1:0] quo [twpw_pkg::LANES];
  logic                       div_done;

  always_comb begin
    den    = twpw_pkg::NUM_W'(wxp_r) + twpw_pkg::NUM_W'(wxq_r) + twpw_pkg::NUM_W'(wyq_r);
    num[0] = twpw_pkg::NUM_W'(wxp_r);
    num[1] = twpw_pkg::NUM_W'(wxq_r) + twpw_pkg::NUM_W'(wyq_r);
    num[2] = twpw_pkg::NUM_W'(wyq_r);
    num[3] = twpw_pkg::NUM_W'(wxp_r) + twpw_pkg::NUM_W'(wxq_r);
  end

  twpw_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .den  (den),
    .num  (num),
    .done (div_done),
    .quo  (quo)
  );

  // Accumulators: cleared at walk start, one add per lane per occurrence.
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      for (int i = 0; i < twpw_pkg::MAX_COLS; i++) begin
        acc_fc_r[i] <= '0;
        acc_sc_r[i] <= '0;
      end
      for (int i = 0; i < twpw_pkg::MAX_ROWS; i++) begin
        acc_fr_r[i] <= '0;
        acc_mr_r[i] <= '0;
      end
    end else if (cmd.acc_add) begin
      acc_fc_r[p_r] <= acc_fc_r[p_r] + twpw_pkg::ACC_W'(quo[0]);
      acc_sc_r[q_r] <= acc_sc_r[q_r] + twpw_pkg::ACC_W'(quo[1]);
      acc_fr_r[y_r] <= acc_fr_r[y_r] + twpw_pkg::ACC_W'(quo[2]);
      acc_mr_r[x_r] <= acc_mr_r[x_r] + twpw_pkg::ACC_W'(quo[3]);
    end
  end

  // Result sequencing over the four vectors.
  logic [twpw_pkg::CNT_W-1:0] vec_len;
  logic                       idx_last, emit_last;
  logic [twpw_pkg::ACC_W-1:0] emit_value;

  always_comb begin
    vec_len   = (esel_r == twpw_pkg::SEL_FIRST_COL || esel_r == twpw_pkg::SEL_SECOND_COL)
                ? nc : nr;
    idx_last  = (twpw_pkg::CNT_W'(eidx_r) + twpw_pkg::CNT_W'(1) == vec_len);
    emit_last = idx_last && (esel_r == twpw_pkg::SEL_MID_ROW);
    unique case (esel_r)
      twpw_pkg::SEL_FIRST_COL:  emit_value = acc_fc_r[eidx_r[twpw_pkg::COL_W-1:0]];
      twpw_pkg::SEL_SECOND_COL: emit_value = acc_sc_r[eidx_r[twpw_pkg::COL_W-1:0]];
      twpw_pkg::SEL_FAR_ROW:    emit_value = acc_fr_r[eidx_r[twpw_pkg::ROW_W-1:0]];
      default:                  emit_value = acc_mr_r[eidx_r[twpw_pkg::ROW_W-1:0]];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      esel_r <= twpw_pkg::SEL_FIRST_COL;
      eidx_r <= '0;
    end else if (cmd.emit_load) begin
      if (idx_last) begin
        esel_r <= esel_r + 2'd1;
        eidx_r <= '0;
      end else begin
        eidx_r <= eidx_r + 4'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_select_r <= esel_r;
      out_index_r  <= eidx_r;
      out_value_r  <= emit_value;
      out_last_r   <= emit_last;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.x_ok      = (wxp_r != '0) && (rdata != '0);
    status.y_ok      = (wyq_r != '0) && (rdata == '0);
    status.y_eq_x    = (y_r == x_r);
    status.y_last    = (twpw_pkg::CNT_W'(y_r) + twpw_pkg::CNT_W'(1) == nr);
    status.walk_last = pair_last && (twpw_pkg::CNT_W'(x_r) + twpw_pkg::CNT_W'(1) == nr);
    status.div_done  = div_done;
    status.out_free  = !out_valid_r || out_ready;
    status.emit_last = emit_last;
  end

  assign out_valid  = out_valid_r;
  assign out_select = out_select_r;
  assign out_index  = out_index_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

### rtl/twpw_ctrl.sv
// Controller: sequences load, the pair walk, division and result output.
// Depends on twpw_pkg.
`timescale 1ns / 1ps

module twpw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  twpw_pkg::status_t status,
  output twpw_pkg::cmd_t    cmd
);

  twpw_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= twpw_pkg::S_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    logic fin_x, adv_y;
    cmd          = '0;
    cmd.addr_sel = twpw_pkg::ADDR_XP;
    state_nxt    = state_r;
    in_ready     = 1'b0;
    fin_x        = 1'b0;
    adv_y        = 1'b0;
    unique case (state_r)
      twpw_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (in_last) begin
            cmd.start_walk = 1'b1;
            state_nxt      = twpw_pkg::S_XP;
          end
        end
      end
      twpw_pkg::S_XP: begin
        state_nxt = twpw_pkg::S_XQ;
      end
      twpw_pkg::S_XQ: begin
        cmd.addr_sel = twpw_pkg::ADDR_XQ;
        cmd.cap_wxp  = 1'b1;
        state_nxt    = twpw_pkg::S_XCHK;
      end
      twpw_pkg::S_XCHK: begin
        if (status.x_ok) begin
          cmd.cap_wxq = 1'b1;
          cmd.reset_y = 1'b1;
          state_nxt   = twpw_pkg::S_YQ;
        end else begin
          fin_x = 1'b1;
        end
      end
      twpw_pkg::S_YQ: begin
        cmd.addr_sel = twpw_pkg::ADDR_YQ;
        if (status.y_eq_x) adv_y = 1'b1;
        else               state_nxt = twpw_pkg::S_YP;
      end
      twpw_pkg::S_YP: begin
        cmd.addr_sel = twpw_pkg::ADDR_YP;
        cmd.cap_wyq  = 1'b1;
        state_nxt    = twpw_pkg::S_YCHK;
      end
      twpw_pkg::S_YCHK: begin
        if (status.y_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = twpw_pkg::S_DIV;
        end else begin
          adv_y = 1'b1;
        end
      end
      twpw_pkg::S_DIV: begin
        if (status.div_done) begin
          cmd.acc_add = 1'b1;
          adv_y       = 1'b1;
        end
      end
      twpw_pkg::S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) state_nxt = twpw_pkg::S_LOAD;
        end
      end
      default: state_nxt = twpw_pkg::S_LOAD;
    endcase

    // Next far row, or move on to the next middle row.
    if (adv_y) begin
      if (status.y_last) begin
        fin_x = 1'b1;
      end else begin
        cmd.next_y = 1'b1;
        state_nxt  = twpw_pkg::S_YQ;
      end
    end

    // Next middle row or column pair; the walk ends after the last one.
    if (fin_x) begin
      if (status.walk_last) begin
        cmd.emit_start = 1'b1;
        state_nxt      = twpw_pkg::S_EMIT;
      end else begin
        cmd.next_x = 1'b1;
        state_nxt  = twpw_pkg::S_XP;
      end
    end
  end

endmodule

### rtl/three_edge_path_weighted_position.sv
// Operation: weight words are stored in the load state. After the last word the
// pair walk steps XP, XQ and XCHK per (column pair, middle row), then YQ, YP and
// YCHK per far row other than the middle row (only YQ for the middle row itself),
// and waits in DIV on the four-lane bit-serial divider per matching motif. A new
// matrix is taken once the last result has been loaded into the output register.
// Reset: synchronous, active low; registers return to 16 rows and 16 columns.
`timescale 1ns / 1ps

module three_edge_path_weighted_position (
  input  logic                            clk,
  input  logic                            rst_n,
  twpw_in_if.sink                         in_ch,
  twpw_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [twpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twpw_pkg::CNT_W-1:0]      cfg_wdata
);

  twpw_pkg::cmd_t    cmd;
  twpw_pkg::status_t status;

  twpw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_last (in_ch.last_weight),
    .in_ready(in_ch.ready),
    .status  (status),
    .cmd     (cmd)
  );

  twpw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_weight (in_ch.weight),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_select(out_ch.vector_select),
    .out_index (out_ch.node_index),
    .out_value (out_ch.contribution),
    .out_last  (out_ch.last_result)
  );

endmodule

### tb/sv/twpw_result_checker.sv
// Result checker for the path weighted position counter (paths of three links).
// Watches the weight, result and register ports; depends on twpw_pkg and twpw_if.
`timescale 1ns / 1ps

module twpw_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  twpw_in_if                              in_ch,
  twpw_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [twpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [twpw_pkg::CNT_W-1:0]      cfg_wdata,
  output int                              error_count,
  output int                              pending_count
);
  import twpw_pkg::*;

  typedef struct packed {
    logic [1:0]       vector_select;
    logic [3:0]       node_index;
    logic [ACC_W-1:0] contribution;
    logic             last_result;
  } share_word_t;

  logic [WEIGHT_W-1:0] matrix_mem [STORE_DEPTH];
  logic [ACC_W-1:0]    first_col_sum  [MAX_COLS];
  logic [ACC_W-1:0]    second_col_sum [MAX_COLS];
  logic [ACC_W-1:0]    far_row_sum    [MAX_ROWS];
  logic [ACC_W-1:0]    mid_row_sum    [MAX_ROWS];
  logic [7:0]          fill_pos;
  logic [CNT_W-1:0]    rows_reg;
  logic [CNT_W-1:0]    cols_reg;
  share_word_t         share_queue[$];

  function automatic int node_count(input logic [CNT_W-1:0] v, input int hi);
    int n;
    n = int'(v);
    if (n < 2) n = 2;
    if (n > hi) n = hi;
    return n;
  endfunction

  function automatic logic [WEIGHT_W-1:0] cell_at(input int r, input int c, input int nc);
    return matrix_mem[(r * nc + c) % STORE_DEPTH];
  endfunction

  // Truncated Q16.16 quotient num / den.
  function automatic logic [ACC_W-1:0] frac_share(input logic [17:0] num,
                                                  input logic [17:0] den);
    logic [47:0] wide;
    wide = {14'd0, num, 16'd0} / {30'd0, den};
    return wide[ACC_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Walk every column pair and row pair and queue the four share vectors.
  task automatic count_motif_shares();
    int nr, nc, n;
    logic [17:0] wxp, wxq, wyq, den;
    share_word_t sw;
    nr = node_count(rows_reg, MAX_ROWS);
    nc = node_count(cols_reg, MAX_COLS);
    for (int i = 0; i < MAX_COLS; i++) begin
      first_col_sum[i] = '0;
      second_col_sum[i] = '0;
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      far_row_sum[i] = '0;
      mid_row_sum[i] = '0;
    end
    for (int p = 0; p < nc; p++) begin
      for (int q = 0; q < nc; q++) begin
        if (p == q) continue;
        for (int x = 0; x < nr; x++) begin
          wxp = 18'(cell_at(x, p, nc));
          wxq = 18'(cell_at(x, q, nc));
          if (wxp == 0 || wxq == 0) continue;
          for (int y = 0; y < nr; y++) begin
            if (x == y) continue;
            wyq = 18'(cell_at(y, q, nc));
            if (wyq == 0 || cell_at(y, p, nc) != 0) continue;
            den = wxp + wxq + wyq;
            mid_row_sum[x]    += frac_share(wxp + wxq, den);
            far_row_sum[y]    += frac_share(wyq, den);
            second_col_sum[q] += frac_share(wxq + wyq, den);
            first_col_sum[p]  += frac_share(wxp, den);
          end
        end
      end
    end
    n = 0;
    for (int sel = 0; sel < 4; sel++) begin
      for (int i = 0; i < ((sel < 2) ? nc : nr); i++) begin
        sw.vector_select = 2'(sel);
        sw.node_index = 4'(i);
        case (2'(sel))
          SEL_FIRST_COL:  sw.contribution = first_col_sum[i];
          SEL_SECOND_COL: sw.contribution = second_col_sum[i];
          SEL_FAR_ROW:    sw.contribution = far_row_sum[i];
          default:        sw.contribution = mid_row_sum[i];
        endcase
        sw.last_result = 1'b0;
        share_queue.push_back(sw);
        n++;
      end
    end
    share_queue[share_queue.size() - 1].last_result = 1'b1;
  endtask

  // All three ports are sampled on the rising edge, before the drivers update.
  always @(posedge clk) begin
    share_word_t want;
    if (!rst_n) begin
      fill_pos = '0;
      rows_reg = CNT_W'(MAX_ROWS);
      cols_reg = CNT_W'(MAX_COLS);
      share_queue.delete();
      error_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) rows_reg = cfg_wdata;
        else if (cfg_index == REG_COLS) cols_reg = cfg_wdata;
      end
      // Weight word: store it while the matrix is not full; the last one starts a count.
      if (in_ch.valid && in_ch.ready) begin
        if (int'(fill_pos) < node_count(rows_reg, MAX_ROWS) * node_count(cols_reg, MAX_COLS))
        begin
          matrix_mem[fill_pos] = in_ch.weight;
          fill_pos = fill_pos + 8'd1;
        end
        if (in_ch.last_weight) begin
          count_motif_shares();
          fill_pos = '0;
        end
      end
      // Result word: compare with the oldest queued share.
      if (out_ch.valid && out_ch.ready) begin
        if (share_queue.size() == 0) begin
          report_mismatch("unexpected result word", {out_ch.vector_select,
                          out_ch.node_index, out_ch.contribution}, '0);
        end else begin
          want = share_queue.pop_front();
          if (out_ch.vector_select !== want.vector_select)
            report_mismatch("vector_select", out_ch.vector_select, want.vector_select);
          if (out_ch.node_index !== want.node_index)
            report_mismatch("node_index", out_ch.node_index, want.node_index);
          if (out_ch.contribution !== want.contribution)
            report_mismatch("contribution", out_ch.contribution, want.contribution);
          if (out_ch.last_result !== want.last_result)
            report_mismatch("last_result", out_ch.last_result, want.last_result);
        end
      end
    end
    pending_count = share_queue.size();
  end

endmodule

### tb/sv/testbench.sv
// Top of the testbench: drives matrices and register writes into the counter.
// Depends on twpw_pkg, twpw_if, twpw_result_checker and the counter itself.
`timescale 1ns / 1ps

module testbench;
  import twpw_pkg::*;

  localparam int IDLE_LIMIT    = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET   = 120;

  typedef enum int { MAT_FULL, MAT_OVERFLOW, MAT_EARLY } matrix_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wdata;
  int                   error_count;
  int                   pending_count;
  int                   idle_cycles;
  int                   burst_left;
  int                   fill_pos;
  int                   eff_rows;
  int                   eff_cols;
  int                   sent_items;
  int                   stall_mode;
  int                   stall_timer;
  logic                 written [STORE_DEPTH];

  twpw_in_if  in_if();
  twpw_out_if out_if();

  three_edge_path_weighted_position u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  twpw_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls: the mode switches whenever a random timer runs out.
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= $urandom_range(0, 1);
      default: out_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int node_count(input logic [CNT_W-1:0] v, input int hi);
    int n;
    n = int'(v);
    if (n < 2) n = 2;
    if (n > hi) n = hi;
    return n;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight(input int zero_pct);
    logic [WEIGHT_W-1:0] w;
    if ($urandom_range(0, 99) < zero_pct) w = '0;
    else begin
      case ($urandom_range(0, 5))
        0:       w = 16'hFFFF;
        1:       w = 16'h0001;
        default: w = 16'($urandom_range(1, 65535));
      endcase
    end
    return w;
  endfunction

  // Send one weight word; the sender idles between bursts.
  task automatic send_word(input logic [WEIGHT_W-1:0] w, input logic lw);
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 20);
    end
    in_if.valid       <= 1'b1;
    in_if.weight      <= w;
    in_if.last_weight <= lw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    sent_items++;
    if (fill_pos < eff_rows * eff_cols) begin
      written[fill_pos] = 1'b1;
      fill_pos++;
    end
    if (lw) fill_pos = 0;
  endtask

  // Hold the sender until every queued share has come back, then settle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CNT_W-1:0] rv, input logic [CNT_W-1:0] cv);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rv;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= cv;
    @(posedge clk);
    // An index past the register list must leave both registers alone.
    if ($urandom_range(0, 2) == 0) begin
      cfg_index <= CFG_IDX_W'($urandom_range(2, 15));
      cfg_wdata <= CNT_W'($urandom_range(0, 31));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    eff_rows = node_count(rv, MAX_ROWS);
    eff_cols = node_count(cv, MAX_COLS);
  endtask

  // One matrix: complete, with extra words dropped, or ended early over old cells.
  task automatic send_matrix(input matrix_kind_t kind, input int zero_pct);
    int n, k, kmin;
    n = eff_rows * eff_cols;
    k = n;
    if (kind == MAT_EARLY) begin
      kmin = n;
      while (kmin > 1 && written[kmin - 1]) kmin--;
      k = $urandom_range(kmin, n);
    end
    for (int i = 0; i < k; i++)
      send_word(pick_weight(zero_pct), (kind != MAT_OVERFLOW) && (i == k - 1));
    if (kind == MAT_OVERFLOW) begin
      for (int i = $urandom_range(1, 4); i > 0; i--)
        send_word(pick_weight(zero_pct), i == 1);
    end
  endtask

  initial begin
    matrix_kind_t kind;
    int pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.weight = '0;
    in_if.last_weight = 1'b0;
    out_if.ready = 1'b0;
    stall_mode = 0;
    stall_timer = 0;
    idle_cycles = 0;
    burst_left = 0;
    fill_pos = 0;
    eff_rows = MAX_ROWS;
    eff_cols = MAX_COLS;
    sent_items = 0;
    for (int i = 0; i < STORE_DEPTH; i++) written[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest matrix holding one motif, with extreme weights.
    set_dims(5'd2, 5'd2);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // Extra words past a full matrix are dropped.
    send_word(16'h8000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h00FF, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // Early last mark: the last two cells keep their old weights.
    send_word(16'h0000, 1'b0);
    send_word(16'h4321, 1'b1);
    // Counts below the floor saturate to two rows.
    set_dims(5'd1, 5'd3);
    for (int i = 0; i < 6; i++) send_word(pick_weight(30), i == 5);
    set_dims(5'd0, 5'd2);
    for (int i = 0; i < 4; i++) send_word(pick_weight(20), i == 3);
    // Counts above the ceiling saturate to the full size, one side at a time.
    set_dims(5'd31, 5'd2);
    for (int i = 0; i < MAX_ROWS * 2; i++)
      send_word(pick_weight(30), i == MAX_ROWS * 2 - 1);
    set_dims(5'd2, 5'd17);
    for (int i = 0; i < MAX_COLS * 2; i++)
      send_word(pick_weight(30), i == MAX_COLS * 2 - 1);

    // Random matrices, mostly small and complete.
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0)
        set_dims(CNT_W'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 6)));
      else if ($urandom_range(0, 1) == 0)
        set_dims(CNT_W'($urandom_range(2, 5)), CNT_W'($urandom_range(2, 5)));
      else if ($urandom_range(0, 7) == 0)
        set_dims(CNT_W'($urandom_range(6, 8)), CNT_W'($urandom_range(6, 8)));
      pick = $urandom_range(0, 9);
      kind = (pick < 8) ? MAT_FULL : (pick == 8) ? MAT_OVERFLOW : MAT_EARLY;
      send_matrix(kind, $urandom_range(10, 60));
    end

    wait_drained();
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
